FILE: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Character codes and sizes shared by the string unescape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_LC_T   = 8'h74;
  localparam byte_t CH_LC_B   = 8'h62;
  localparam byte_t CH_LC_F   = 8'h66;
  localparam byte_t CH_LC_N   = 8'h6E;
  localparam byte_t CH_LC_R   = 8'h72;
  localparam byte_t CH_LC_U   = 8'h75;
  localparam byte_t CH_LC_A   = 8'h61;
  localparam byte_t CH_UC_A   = 8'h41;
  localparam byte_t CH_UC_F   = 8'h46;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_7      = 8'h37;
  localparam byte_t CH_9      = 8'h39;

  localparam byte_t CTL_TAB   = 8'h09;
  localparam byte_t CTL_BS    = 8'h08;
  localparam byte_t CTL_FF    = 8'h0C;
  localparam byte_t CTL_LF    = 8'h0A;
  localparam byte_t CTL_CR    = 8'h0D;

  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

endpackage

`default_nettype wire

FILE: src/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for the escapes of one string value: one raw byte per
// input transfer, zero to six unescaped bytes per input byte on the output.
// ----------------------------------------------------------------------------
// Latency: first result byte is valid the cycle after its input transfer.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and the output is not stalled; a byte yielding several results holds
//   the input until the six-byte result buffer drains, one byte per output transfer.
// Reset: synchronous, active low; clears decode mode, held digit and the
//   result count, read index and last flag; result bytes are not cleared.
`default_nettype none

module json_string_unescape (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire jsu_pkg::byte_t        in_tdata,   // [7:0] in_byte
  input  wire logic                  in_tlast,   // end_of_record
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output jsu_pkg::byte_t             out_tdata,  // [7:0] out_byte
  output logic                       out_tlast   // out_last
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_COPY,
    MODE_ESC,
    MODE_U,
    MODE_U0,
    MODE_U00,
    MODE_UD
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [2:0]           held_r, held_nxt;
  byte_t                buf_r [MAX_RESULTS];
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_CNT_W-1:0] idx_r;
  logic                 last_r;

  byte_t                rb [MAX_RESULTS];
  logic [RES_CNT_W-1:0] rc;
  logic                 flush;
  logic                 plain;
  logic [3:0]           hex_val;
  logic                 is_hex;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 out_final;

  assign out_tvalid = (cnt_r != '0);
  assign out_final  = (idx_r == cnt_r - RES_CNT_W'(1));
  assign out_tdata  = buf_r[idx_r[RES_IDX_W-1:0]];
  assign out_tlast  = last_r && out_final;
  assign out_xfer   = out_tvalid && out_tready;
  // accept while the buffer is empty or its final byte leaves this cycle
  assign in_tready  = !out_tvalid || (out_xfer && out_final);
  assign in_xfer    = in_tvalid && in_tready;

  always_comb begin
    is_hex  = (in_tdata inside {[CH_0:CH_9], [CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]});
    hex_val = (in_tdata <= CH_9) ? 4'(in_tdata - CH_0)
                                 : ({1'b0, in_tdata[2:0]} + HEX_ALPHA_OFS);
  end

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rb[i] = '0;
    end
    rc       = '0;
    flush    = 1'b0;
    plain    = 1'b0;
    mode_nxt = mode_r;
    held_nxt = held_r;

    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_COPY;
        rc       = RES_CNT_W'(1);
        case (in_tdata)
          CH_LC_T:   rb[0] = CTL_TAB;
          CH_LC_B:   rb[0] = CTL_BS;
          CH_LC_F:   rb[0] = CTL_FF;
          CH_LC_N:   rb[0] = CTL_LF;
          CH_LC_R:   rb[0] = CTL_CR;
          CH_BSLASH: rb[0] = CH_BSLASH;
          CH_QUOTE:  rb[0] = CH_QUOTE;
          CH_LC_U: begin
            if (in_tlast) begin
              rb[0] = CH_BSLASH;
              rb[1] = CH_LC_U;
              rc    = RES_CNT_W'(2);
            end else begin
              rc       = '0;
              mode_nxt = MODE_U;
            end
          end
          default: begin
            rb[0] = CH_BSLASH;
            rb[1] = in_tdata;
            rc    = RES_CNT_W'(2);
          end
        endcase
      end
      MODE_U, MODE_U0: begin
        if (in_tdata == CH_0 && !in_tlast) begin
          mode_nxt = (mode_r == MODE_U) ? MODE_U0 : MODE_U00;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_U00: begin
        if (in_tdata >= CH_0 && in_tdata <= CH_7 && !in_tlast) begin
          held_nxt = in_tdata[2:0];
          mode_nxt = MODE_UD;
        end else begin
          flush = 1'b1;
        end
      end
      MODE_UD: begin
        if (is_hex) begin
          rb[0]    = {1'b0, held_r, hex_val};
          rc       = RES_CNT_W'(1);
          mode_nxt = MODE_COPY;
        end else begin
          flush = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase

    // emit the held part of a broken u sequence, then treat the byte as plain
    if (flush) begin
      plain = 1'b1;
      rb[0] = CH_BSLASH;
      rb[1] = CH_LC_U;
      rb[2] = CH_0;
      rb[3] = CH_0;
      rb[4] = CH_0 | {5'b0, held_r};
      case (mode_r)
        MODE_U0:  rc = RES_CNT_W'(3);
        MODE_U00: rc = RES_CNT_W'(4);
        MODE_UD:  rc = RES_CNT_W'(5);
        default:  rc = RES_CNT_W'(2);
      endcase
    end

    if (plain) begin
      if (in_tdata == CH_BSLASH && !in_tlast) begin
        mode_nxt = MODE_ESC;
      end else begin
        rb[rc[RES_IDX_W-1:0]] = in_tdata;
        rc       = rc + RES_CNT_W'(1);
        mode_nxt = MODE_COPY;
      end
    end

    if (in_tlast) begin
      mode_nxt = MODE_COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COPY;
      held_r <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
      last_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        mode_r <= mode_nxt;
        held_r <= held_nxt;
        cnt_r  <= rc;
        idx_r  <= '0;
        last_r <= in_tlast;
      end else if (out_xfer) begin
        if (out_final) begin
          cnt_r <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + RES_CNT_W'(1);
        end
      end
    end
  end

  // result bytes; load on every input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_r[i] <= rb[i];
      end
    end
  end

endmodule

`default_nettype wire
